### rtl/rvc_pkg.sv
package rvc_pkg;

	localparam int XLEN       = 32;
	localparam int REG_COUNT  = 32;
	localparam int REG_IDX_W  = $clog2(REG_COUNT);
	// word-indexed data memory; the index is the low bits of the address sum,
	// so the depth is kept to a power of two
	localparam int DATA_WORDS = 128;
	localparam int MEM_IDX_W  = $clog2(DATA_WORDS);

	localparam logic [6:0] OP_RTYPE  = 7'b0110011;
	localparam logic [6:0] OP_ITYPE  = 7'b0010011;
	localparam logic [6:0] OP_LOAD   = 7'b0000011;
	localparam logic [6:0] OP_STORE  = 7'b0100011;
	localparam logic [6:0] OP_BRANCH = 7'b1100011;

	localparam logic [2:0] F3_ADD = 3'b000;
	localparam logic [2:0] F3_XOR = 3'b100;
	localparam logic [2:0] F3_OR  = 3'b110;
	localparam logic [6:0] F7_ZERO = 7'b0000000;

	typedef struct packed {
		logic                 en;
		logic [REG_IDX_W-1:0] idx;
		logic [XLEN-1:0]      data;
	} rf_wr_t;

	typedef struct packed {
		logic [XLEN-1:0]      next_pc;
		logic                 taken;
		logic                 rwe;
		logic [REG_IDX_W-1:0] rd;
		logic [XLEN-1:0]      wb;
		logic                 mwe;
		logic                 is_load;
		logic [MEM_IDX_W-1:0] midx;
		logic [XLEN-1:0]      mval;
	} exec_t;

endpackage

### rtl/rv32_subset_single_cycle_core_top.sv
// Small RV32I-subset core: add, sub, xor, or, and, their immediate forms,
// lw, sw and beq. One instruction word is taken on the input channel
// (in_valid/in_ready, instruction_word), and one result beat leaves on the
// output channel (out_valid/out_ready) telling the next fetch address and
// the register and memory writes the instruction made.
// The first instruction is expected from address 0; the host fetches each
// next word from the reported next_pc.
// An accepted word is registered in instr_s1, and its result in res_s2,
// which drives the output. Throughput is one instruction per cycle while
// the output is not stalled; the cycle is set by the load-data forwarding
// path into the address adder in front of the data memory port.
// A stalled output holds its beat; the stage behind it keeps one more
// instruction, then in_ready drops until out_ready returns.
// Reset (arst_n low) sets the program counter to 0 and all registers to
// zero at once through per-register valid bits; there is no clearing pass.
// Data memory contents are undefined until a store writes them.
module rv32_subset_single_cycle_core_top import rvc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [31:0]           instruction_word,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [31:0]           next_pc,
	output logic                  branch_taken,
	output logic                  reg_write_en,
	output logic [4:0]            reg_index,
	output logic signed [31:0]    reg_value,
	output logic                  mem_write_en,
	output logic [MEM_IDX_W-1:0]  mem_index,
	output logic signed [31:0]    mem_value
);

	logic                 valid_s1;
	logic [31:0]          instr_s1;
	logic                 valid_s2;
	exec_t                res_s2;
	logic                 wb_done_q;
	logic [XLEN-1:0]      pc_q;

	logic                 accept;
	logic                 adv_s1;
	logic [REG_IDX_W-1:0] rd_addr1;
	logic [REG_IDX_W-1:0] rd_addr2;
	logic [XLEN-1:0]      a;
	logic [XLEN-1:0]      b;
	exec_t                ex;
	rf_wr_t               rf_wr;
	logic [XLEN-1:0]      dmem_rdata;
	logic [XLEN-1:0]      wb_value;

	assign adv_s1   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv_s1;
	assign accept   = in_valid && in_ready;

	assign rd_addr1 = accept ? instruction_word[19:15] : instr_s1[19:15];
	assign rd_addr2 = accept ? instruction_word[24:20] : instr_s1[24:20];

	assign wb_value = res_s2.is_load ? dmem_rdata : res_s2.wb;

	// the result beat commits its register write once, the edge after it lands
	assign rf_wr.en   = valid_s2 && !wb_done_q && res_s2.rwe && (res_s2.rd != '0);
	assign rf_wr.idx  = res_s2.rd;
	assign rf_wr.data = wb_value;

	rvc_regfile u_regfile (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_addr1 (rd_addr1),
		.rd_addr2 (rd_addr2),
		.rs1      (instr_s1[19:15]),
		.rs2      (instr_s1[24:20]),
		.wr       (rf_wr),
		.a        (a),
		.b        (b)
	);

	rvc_exec u_exec (
		.instr (instr_s1),
		.pc    (pc_q),
		.a     (a),
		.b     (b),
		.res   (ex)
	);

	// load data is read only as the load moves on, so it holds under stall
	rvc_ram #(.WIDTH(XLEN), .DEPTH(DATA_WORDS)) u_dmem (
		.clk   (clk),
		.we    (adv_s1 && ex.mwe),
		.waddr (ex.midx),
		.wdata (ex.mval),
		.re    (adv_s1 && ex.is_load),
		.raddr (ex.midx),
		.rdata (dmem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			wb_done_q <= 1'b0;
			pc_q      <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (!valid_s2 || out_ready) begin
				valid_s2 <= valid_s1;
			end
			if (adv_s1) begin
				wb_done_q <= 1'b0;
				pc_q      <= ex.next_pc;
			end else if (valid_s2) begin
				wb_done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			instr_s1 <= instruction_word;
		end
		if (adv_s1) begin
			res_s2 <= ex;
		end
	end

	assign out_valid    = valid_s2;
	assign next_pc      = res_s2.next_pc;
	assign branch_taken = res_s2.taken;
	assign reg_write_en = res_s2.rwe;
	assign reg_index    = res_s2.rd;
	assign reg_value    = $signed(wb_value);
	assign mem_write_en = res_s2.mwe;
	assign mem_index    = res_s2.midx;
	assign mem_value    = $signed(res_s2.mval);

	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("s1 empty but input not ready");

	a_branch_excl: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && branch_taken |-> !reg_write_en && !mem_write_en)
		else $error("taken branch reports a write");

	a_new_beat_commits: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> valid_s2 && !wb_done_q)
		else $error("new result beat marked as already written back");

	a_write_once: assert property (@(posedge clk) disable iff (!arst_n)
		rf_wr.en && !adv_s1 |=> wb_done_q && !rf_wr.en)
		else $error("register write repeated for one beat");

endmodule

### rtl/rvc_ram.sv
module rvc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// a read at the address being written returns the old word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/rvc_regfile.sv
module rvc_regfile import rvc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [REG_IDX_W-1:0] rd_addr1,
	input  logic [REG_IDX_W-1:0] rd_addr2,
	input  logic [REG_IDX_W-1:0] rs1,
	input  logic [REG_IDX_W-1:0] rs2,
	input  rf_wr_t               wr,
	output logic [XLEN-1:0]      a,
	output logic [XLEN-1:0]      b
);

	logic [REG_COUNT-1:0] valid_q;
	rf_wr_t               last_q;
	logic [XLEN-1:0]      bank1_rdata;
	logic [XLEN-1:0]      bank2_rdata;

	// two copies give two read ports
	rvc_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_bank1 (
		.clk   (clk),
		.we    (wr.en),
		.waddr (wr.idx),
		.wdata (wr.data),
		.re    (1'b1),
		.raddr (rd_addr1),
		.rdata (bank1_rdata)
	);

	rvc_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_bank2 (
		.clk   (clk),
		.we    (wr.en),
		.waddr (wr.idx),
		.wdata (wr.data),
		.re    (1'b1),
		.raddr (rd_addr2),
		.rdata (bank2_rdata)
	);

	// newest first: write in flight, write at the last edge, then the bank; zero if never written
	function automatic logic [XLEN-1:0] pick(
		input logic [REG_IDX_W-1:0] idx,
		input rf_wr_t               cur,
		input rf_wr_t               last,
		input logic                 vld,
		input logic [XLEN-1:0]      ram
	);
		logic [XLEN-1:0] val;
		if (cur.en && cur.idx == idx) begin
			val = cur.data;
		end else if (last.en && last.idx == idx) begin
			val = last.data;
		end else if (vld) begin
			val = ram;
		end else begin
			val = '0;
		end
		return val;
	endfunction

	assign a = pick(rs1, wr, last_q, valid_q[rs1], bank1_rdata);
	assign b = pick(rs2, wr, last_q, valid_q[rs2], bank2_rdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			last_q  <= '0;
		end else begin
			if (wr.en) begin
				valid_q[wr.idx] <= 1'b1;
			end
			last_q <= wr;
		end
	end

endmodule

### rtl/rvc_exec.sv
module rvc_exec import rvc_pkg::*; (
	input  logic [31:0]     instr,
	input  logic [XLEN-1:0] pc,
	input  logic [XLEN-1:0] a,
	input  logic [XLEN-1:0] b,
	output exec_t           res
);

	logic [6:0]      op;
	logic [2:0]      f3;
	logic [6:0]      f7;
	logic [XLEN-1:0] imm_i;
	logic [XLEN-1:0] imm_s;
	logic [XLEN-1:0] imm_b;
	logic [XLEN-1:0] sum_i;
	logic [XLEN-1:0] sum_s;

	assign op    = instr[6:0];
	assign f3    = instr[14:12];
	assign f7    = instr[31:25];
	assign imm_i = {{20{instr[31]}}, instr[31:20]};
	assign imm_s = {{20{instr[31]}}, instr[31:25], instr[11:7]};
	assign imm_b = {{19{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
	assign sum_i = a + imm_i;
	assign sum_s = a + imm_s;

	function automatic logic [XLEN-1:0] alu(
		input logic [XLEN-1:0] x,
		input logic [XLEN-1:0] y,
		input logic [2:0]      fn,
		input logic            sub
	);
		logic [XLEN-1:0] r;
		unique case (fn)
			F3_ADD:  r = sub ? x - y : x + y;
			F3_XOR:  r = x ^ y;
			F3_OR:   r = x | y;
			default: r = x & y;
		endcase
		return r;
	endfunction

	always_comb begin
		res         = '0;
		res.next_pc = pc + XLEN'(4);
		res.rd      = instr[11:7];
		unique case (op)
			OP_RTYPE: begin
				res.rwe = 1'b1;
				res.wb  = alu(a, b, f3, f7 != F7_ZERO);
			end
			OP_ITYPE: begin
				res.rwe = 1'b1;
				res.wb  = alu(a, imm_i, f3, 1'b0);
			end
			OP_LOAD: begin
				res.rwe     = 1'b1;
				res.is_load = 1'b1;
				res.midx    = sum_i[MEM_IDX_W-1:0];
			end
			OP_STORE: begin
				res.mwe  = 1'b1;
				res.midx = sum_s[MEM_IDX_W-1:0];
				res.mval = b;
			end
			OP_BRANCH: begin
				// every branch acts as beq
				if (a == b) begin
					res.taken   = 1'b1;
					res.next_pc = pc + imm_b;
				end
			end
			default: ;
		endcase
	end

endmodule

### tb/sv/tb_rv32_subset_single_cycle_core_top.sv
`timescale 1ns / 100ps

module tb_rv32_subset_single_cycle_core_top import rvc_pkg::*;;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_INSNS = 2000;
	localparam int LONG_HOLD    = 300;

	localparam logic [6:0] OP_JAL   = 7'b1101111;
	localparam logic [6:0] F7_SUB   = 7'b0100000;
	localparam logic [6:0] F7_ONES  = 7'b1111111;
	localparam logic [2:0] F3_AND   = 3'b111;
	localparam logic [2:0] F3_SLL   = 3'b001;
	localparam logic [2:0] F3_WORD  = 3'b010;

	typedef struct packed {
		logic [31:0]          next_pc;
		logic                 taken;
		logic                 rwe;
		logic [4:0]           rd;
		logic [31:0]          wb;
		logic                 mwe;
		logic [MEM_IDX_W-1:0] midx;
		logic [31:0]          mval;
	} core_result_t;

	typedef struct {
		logic [31:0]  word;
		bit           typed;
		core_result_t exp;
	} dir_row_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [31:0]           instruction_word = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [31:0]           next_pc;
	logic                  branch_taken;
	logic                  reg_write_en;
	logic [4:0]            reg_index;
	logic signed [31:0]    reg_value;
	logic                  mem_write_en;
	logic [MEM_IDX_W-1:0]  mem_index;
	logic signed [31:0]    mem_value;

	// architectural state mirrored by the predictor
	logic [31:0] cur_pc;
	logic [31:0] xreg [REG_COUNT];
	logic [31:0] dmem [DATA_WORDS];
	bit          dmem_written [DATA_WORDS];
	int          stored_words [$];

	core_result_t pending_results [$];
	dir_row_t     dir_rows [25];
	int           mismatches = 0;
	int           cycle_cnt = 0;
	int           feed_calm = 0;
	int           drain_calm = 0;

	rv32_subset_single_cycle_core_top i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.instruction_word(instruction_word),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.next_pc         (next_pc),
		.branch_taken    (branch_taken),
		.reg_write_en    (reg_write_en),
		.reg_index       (reg_index),
		.reg_value       (reg_value),
		.mem_write_en    (mem_write_en),
		.mem_index       (mem_index),
		.mem_value       (mem_value)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic logic [31:0] enc_r(logic [6:0] f7, int rs2, int rs1, logic [2:0] f3,
			int rd);
		return {f7, 5'(rs2), 5'(rs1), f3, 5'(rd), OP_RTYPE};
	endfunction

	function automatic logic [31:0] enc_i(logic [6:0] op, int imm, int rs1, logic [2:0] f3,
			int rd);
		return {12'(imm), 5'(rs1), f3, 5'(rd), op};
	endfunction

	function automatic logic [31:0] enc_s(int imm, int rs2, int rs1, logic [2:0] f3);
		logic [11:0] v;
		v = 12'(imm);
		return {v[11:5], 5'(rs2), 5'(rs1), f3, v[4:0], OP_STORE};
	endfunction

	function automatic logic [31:0] enc_b(int imm, int rs2, int rs1, logic [2:0] f3);
		logic [12:0] v;
		v = 13'(imm);
		return {v[12], v[10:5], 5'(rs2), 5'(rs1), f3, v[4:1], v[11], OP_BRANCH};
	endfunction

	function automatic logic [31:0] alu_result(logic [31:0] a, logic [31:0] b, logic [2:0] f3,
			logic sub);
		case (f3)
			F3_ADD: return sub ? a - b : a + b;
			F3_XOR: return a ^ b;
			F3_OR:  return a | b;
			default: return a & b;
		endcase
	endfunction

	// executes one instruction on the mirrored state and returns its beat
	function automatic core_result_t retire_insn(logic [31:0] w);
		core_result_t r;
		logic [31:0]  a;
		logic [31:0]  b;
		logic [31:0]  imm_i;
		logic [31:0]  imm_s;
		logic [31:0]  imm_b;
		logic [31:0]  addr;
		a = (w[19:15] == 5'd0) ? '0 : xreg[w[19:15]];
		b = (w[24:20] == 5'd0) ? '0 : xreg[w[24:20]];
		imm_i = {{20{w[31]}}, w[31:20]};
		imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
		imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
		r = '0;
		r.rd = w[11:7];
		r.next_pc = cur_pc + 32'd4;
		case (w[6:0])
			OP_RTYPE: begin
				r.rwe = 1'b1;
				r.wb = alu_result(a, b, w[14:12], w[31:25] != F7_ZERO);
			end
			OP_ITYPE: begin
				r.rwe = 1'b1;
				r.wb = alu_result(a, imm_i, w[14:12], 1'b0);
			end
			OP_LOAD: begin
				addr = (a + imm_i) % 32'(DATA_WORDS);
				r.rwe = 1'b1;
				r.midx = addr[MEM_IDX_W-1:0];
				r.wb = dmem[r.midx];
			end
			OP_STORE: begin
				addr = (a + imm_s) % 32'(DATA_WORDS);
				r.mwe = 1'b1;
				r.midx = addr[MEM_IDX_W-1:0];
				r.mval = b;
				dmem[r.midx] = b;
				if (!dmem_written[r.midx]) begin
					dmem_written[r.midx] = 1'b1;
					stored_words.push_back(int'(r.midx));
				end
			end
			OP_BRANCH: begin
				if (a - b == 32'd0) begin
					r.taken = 1'b1;
					r.next_pc = cur_pc + imm_b;
				end
			end
			default: ;
		endcase
		if (r.rwe && r.rd != 5'd0)
			xreg[r.rd] = r.wb;
		cur_pc = r.next_pc;
		return r;
	endfunction

	// mostly well-formed instructions, some raw words; loads only hit stored words
	function automatic logic [31:0] pick_insn();
		logic [31:0] w;
		logic [31:0] base;
		int          roll;
		int          tgt;
		int          span;
		int          k;
		int          imm;
		w = $urandom();
		roll = $urandom_range(0, 99);
		if (roll < 24) begin
			w[6:0] = OP_RTYPE;
			if ($urandom_range(0, 1) == 0)
				w[31:25] = F7_ZERO;
		end else if (roll < 48) begin
			w[6:0] = OP_ITYPE;
		end else if (roll < 61) begin
			w[6:0] = OP_STORE;
		end else if (roll < 74) begin
			w[6:0] = OP_LOAD;
		end else if (roll < 88) begin
			w[6:0] = OP_BRANCH;
			// equal operands so that about half the branches are taken
			if ($urandom_range(0, 1) == 0)
				w[24:20] = w[19:15];
		end else if (roll < 92) begin
			w[6:0] = OP_JAL;
		end
		if (w[6:0] == OP_LOAD) begin
			if (stored_words.size() == 0) begin
				w[6:0] = OP_STORE;
			end else begin
				tgt = stored_words[$urandom_range(0, stored_words.size() - 1)];
				base = (w[19:15] == 5'd0) ? '0 : xreg[w[19:15]];
				span = 2048 / DATA_WORDS;
				k = $urandom_range(0, 2 * span - 1);
				k = k - span;
				imm = int'((32'(tgt) - base) & 32'(DATA_WORDS - 1)) + DATA_WORDS * k;
				w[31:20] = imm[11:0];
			end
		end
		return w;
	endfunction

	// cycles to wait before the next beat, with occasional stretches of none
	function automatic int draw_wait(inout int calm_left);
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 49) == 0) begin
			calm_left = $urandom_range(20, 80);
			return 0;
		end
		return $urandom_range(0, 19);
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// returns at the edge where the beat was taken
	task automatic send_word(logic [31:0] w);
		int gap;
		gap = draw_wait(feed_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		instruction_word <= w;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic issue(logic [31:0] w, bit typed, core_result_t typed_exp);
		core_result_t res;
		send_word(w);
		res = retire_insn(w);
		pending_results.push_back(typed ? typed_exp : res);
	endtask

	initial begin : feed
		logic [31:0] w;
		cur_pc = '0;
		foreach (xreg[i])
			xreg[i] = '0;
		foreach (dmem[i])
			dmem[i] = '0;
		dir_rows = '{
			'{enc_i(OP_ITYPE, -1, 0, F3_ADD, 1), 1'b1,
				'{32'd4, 1'b0, 1'b1, 5'd1, 32'hFFFF_FFFF, 1'b0, 7'd0, 32'd0}},
			'{enc_i(OP_ITYPE, 2047, 0, F3_ADD, 2), 1'b1,
				'{32'd8, 1'b0, 1'b1, 5'd2, 32'h0000_07FF, 1'b0, 7'd0, 32'd0}},
			'{enc_i(OP_ITYPE, -2048, 0, F3_ADD, 3), 1'b1,
				'{32'd12, 1'b0, 1'b1, 5'd3, 32'hFFFF_F800, 1'b0, 7'd0, 32'd0}},
			'{enc_r(F7_ZERO, 2, 1, F3_ADD, 4), 1'b0, '0},
			'{enc_r(F7_ZERO, 1, 1, F3_ADD, 5), 1'b0, '0},
			'{enc_r(F7_SUB, 1, 0, F3_ADD, 6), 1'b0, '0},
			'{enc_r(F7_ONES, 2, 3, F3_ADD, 7), 1'b0, '0},
			'{enc_r(F7_ZERO, 2, 1, F3_XOR, 8), 1'b0, '0},
			'{enc_r(F7_ZERO, 2, 3, F3_OR, 9), 1'b0, '0},
			'{enc_r(F7_ZERO, 2, 1, F3_AND, 10), 1'b0, '0},
			'{enc_r(F7_ZERO, 3, 1, F3_SLL, 11), 1'b0, '0},
			'{enc_i(OP_ITYPE, 1365, 1, F3_XOR, 12), 1'b0, '0},
			'{enc_i(OP_ITYPE, -2048, 2, F3_OR, 13), 1'b0, '0},
			'{enc_i(OP_ITYPE, 240, 1, F3_AND, 14), 1'b0, '0},
			'{enc_i(OP_ITYPE, 5, 1, F3_ADD, 0), 1'b0, '0},
			'{enc_s(0, 1, 0, F3_WORD), 1'b0, '0},
			'{enc_s(-1, 2, 0, F3_WORD), 1'b0, '0},
			'{enc_s(2047, 3, 1, F3_AND), 1'b0, '0},
			'{enc_i(OP_LOAD, 0, 0, F3_WORD, 16), 1'b0, '0},
			'{enc_i(OP_LOAD, -2048, 2, F3_WORD, 17), 1'b0, '0},
			'{enc_b(0, 2, 1, F3_ADD), 1'b0, '0},
			'{enc_b(-4096, 0, 0, F3_ADD), 1'b0, '0},
			'{enc_b(4094, 5, 5, F3_XOR), 1'b0, '0},
			'{enc_i(OP_JAL, 1365, 10, F3_XOR, 9), 1'b0, '0},
			'{32'hFFFF_FFFF, 1'b0, '0}
		};
		while (!arst_n) @(posedge clk);
		foreach (dir_rows[i])
			issue(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].exp);
		repeat (RANDOM_INSNS) begin
			w = pick_insn();
			issue(w, 1'b0, '0);
		end
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (out_valid) begin
			$display("%0t: beat left on the output with nothing expected", $time);
			mismatches++;
		end
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin : drain
		core_result_t exp;
		int           stall;
		int           beats;
		beats = 0;
		while (!arst_n) @(posedge clk);
		forever begin
			stall = draw_wait(drain_calm);
			// hold off long enough for the core to back up and drop in_ready
			if (beats == 400)
				stall = LONG_HOLD;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			beats++;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected beat, next_pc %h", $time, next_pc);
				mismatches++;
			end else begin
				exp = pending_results.pop_front();
				check_field("next_pc", exp.next_pc, next_pc);
				check_field("branch_taken", 32'(exp.taken), 32'(branch_taken));
				check_field("reg_write_en", 32'(exp.rwe), 32'(reg_write_en));
				check_field("reg_index", 32'(exp.rd), 32'(reg_index));
				check_field("reg_value", exp.wb, reg_value);
				check_field("mem_write_en", 32'(exp.mwe), 32'(mem_write_en));
				check_field("mem_index", 32'(exp.midx), 32'(mem_index));
				check_field("mem_value", exp.mval, mem_value);
			end
		end
	end

endmodule
